// ----- design/etu_pkg.sv -----
// shared types, instruction codes and stack helpers for the execute unit
// no dependencies
`default_nettype none
package etu_pkg;

	localparam int unsigned STACK_BASE = 256;
	localparam int unsigned STACK_DEPTH = 256;

	localparam logic [15:0] BASE16 = 16'(STACK_BASE);

	// flag bit positions inside the 6-bit flag word
	localparam int unsigned F_C = 0;
	localparam int unsigned F_Z = 1;
	localparam int unsigned F_I = 2;
	localparam int unsigned F_D = 3;
	localparam int unsigned F_V = 4;
	localparam int unsigned F_N = 5;

	localparam logic [5:0] FLAGS_RESET = 6'b000100;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] BRK_MARK = 8'b0001_0000;
	localparam logic [7:0] ALL_ONES = 8'hFF;

	localparam logic [5:0] K_LDA = 6'd0, K_LDX = 6'd1, K_LDY = 6'd2, K_STA = 6'd3;
	localparam logic [5:0] K_STX = 6'd4, K_STY = 6'd5, K_TAX = 6'd6, K_TAY = 6'd7;
	localparam logic [5:0] K_TXA = 6'd8, K_TYA = 6'd9, K_TSX = 6'd10, K_TXS = 6'd11;
	localparam logic [5:0] K_PHA = 6'd12, K_PHP = 6'd13, K_PLA = 6'd14, K_PLP = 6'd15;
	localparam logic [5:0] K_ADC = 6'd16, K_SBC = 6'd17, K_CMP = 6'd18, K_CPX = 6'd19;
	localparam logic [5:0] K_CPY = 6'd20, K_INC = 6'd21, K_INX = 6'd22, K_INY = 6'd23;
	localparam logic [5:0] K_DEC = 6'd24, K_DEX = 6'd25, K_DEY = 6'd26, K_ASL = 6'd27;
	localparam logic [5:0] K_LSR = 6'd28, K_ROL = 6'd29, K_ROR = 6'd30, K_AND = 6'd31;
	localparam logic [5:0] K_EOR = 6'd32, K_ORA = 6'd33, K_BIT = 6'd34, K_JMP = 6'd35;
	localparam logic [5:0] K_JSR = 6'd36, K_RTS = 6'd37, K_BCC = 6'd38, K_BCS = 6'd39;
	localparam logic [5:0] K_BEQ = 6'd40, K_BMI = 6'd41, K_BNE = 6'd42, K_BPL = 6'd43;
	localparam logic [5:0] K_BVC = 6'd44, K_BVS = 6'd45, K_CLC = 6'd46, K_CLD = 6'd47;
	localparam logic [5:0] K_CLI = 6'd48, K_CLV = 6'd49, K_SEC = 6'd50, K_SED = 6'd51;
	localparam logic [5:0] K_SEI = 6'd52, K_BRK = 6'd53, K_NOP = 6'd54, K_RTI = 6'd55;
	localparam logic [5:0] K_LAX = 6'd56, K_SAX = 6'd57, K_DCP = 6'd58, K_ISB = 6'd59;

	typedef struct packed {
		logic [5:0]       kind;
		logic             to_acc;
		logic [7:0]       operand;
		logic [15:0]      ea;
		logic [15:0]      npc;
		logic [7:0]       a;
		logic [7:0]       x;
		logic [7:0]       y;
		logic [7:0]       sp;
		logic [5:0]       fl;
		logic [15:0]      brk_vec;
		logic [2:0][7:0]  pulled;
	} alu_in_t;

	typedef struct packed {
		logic [7:0]       a;
		logic [7:0]       x;
		logic [7:0]       y;
		logic [7:0]       sp;
		logic [5:0]       fl;
		logic [15:0]      pc;
		logic [1:0]       nw;
		logic [2:0][15:0] wa;
		logic [2:0][7:0]  wd;
		logic             illegal;
	} alu_out_t;

	function automatic logic [7:0] status_of(input logic [5:0] fl);
		return {fl[F_N], fl[F_V], 2'b10, fl[3:0]};
	endfunction

	function automatic logic [1:0] pull_count(input logic [5:0] kind);
		logic [1:0] n;
		n = 2'd0;
		unique case (kind)
			K_PLA, K_PLP: n = 2'd1;
			K_RTS:        n = 2'd2;
			K_RTI:        n = 2'd3;
			default:      n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic in_stack_page(input logic [15:0] addr);
		logic [15:0] d;
		d = addr - BASE16;
		return (addr >= BASE16) && (d[15:8] == 8'd0);
	endfunction

	function automatic logic [7:0] stack_index(input logic [15:0] addr);
		logic [15:0] d;
		d = addr - BASE16;
		return d[7:0];
	endfunction

endpackage
`default_nettype wire

// ----- design/eight_bit_cpu_execute_unit_core.sv -----
// top level of the execute unit: request sequencer, stack memory and result register
// depends on etu_pkg, etu_ram and etu_alu
`default_nettype none
// Executes one decoded instruction per input request and returns one to three
// result requests, one per memory write in write order, or a single result with
// no write. An instruction that pulls first reads its stack bytes upward from
// sp + 1 through the registered read port of the 256-byte stack memory and
// only then emits its results; pushes and stack-page stores use its write port.
// A new request is taken as soon as the last result of the previous one has been
// loaded into the output register, even while that result still waits. The stack
// page reads as zero after reset: a valid flag per byte masks unwritten entries,
// so no clearing pass is needed. break_vector is written through the cfg channel.
module eight_bit_cpu_execute_unit_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config: break_vector
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	// input request
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // operand[7:0], effective_address[23:8], next_pc[39:24]
	input  wire logic [6:0]  s_tuser,   // kind[5:0], to_accumulator[6]
	// result request
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0] m_tdata,   // write_address[15:0], write_data[23:16], new_pc[39:24],
	                               // reg_a[47:40], reg_x[55:48], reg_y[63:56],
	                               // stack_pointer[71:64], status[79:72]
	output logic [1:0]       m_tuser,   // write_valid[0], illegal[1]
	output logic             m_tlast
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PULL = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	// architectural state
	logic [7:0]  a_q, x_q, y_q, sp_q;
	logic [5:0]  fl_q;
	logic [15:0] brk_q;

	// latched request
	logic [5:0]  kind_q;
	logic        to_acc_q;
	logic [7:0]  operand_q;
	logic [15:0] ea_q, npc_q;
	logic [1:0]  npull_q;

	logic [1:0]      state_q;
	logic [1:0]      cnt_q;
	logic [2:0][7:0] pull_q;

	// stack memory and per-byte valid flags
	logic [etu_pkg::STACK_DEPTH-1:0] vb_q;
	logic        ram_we;
	logic [7:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;
	logic        rvb_s1;

	// output register
	logic        m_valid_q;
	logic [79:0] m_data_q;
	logic [1:0]  m_user_q;
	logic        m_last_q;

	etu_pkg::alu_in_t  ai;
	etu_pkg::alu_out_t ao;

	logic        s_acc;
	logic        out_free;
	logic [1:0]  nres;
	logic        w_here;
	logic        is_last;
	logic [15:0] cur_wa;
	logic [7:0]  cur_wd;
	logic [7:0]  pull_byte;
	logic [1:0]  in_npull;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign in_npull  = etu_pkg::pull_count(s_tuser[5:0]);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	// instruction semantics on the latched request
	always_comb begin
		ai.kind    = kind_q;
		ai.to_acc  = to_acc_q;
		ai.operand = operand_q;
		ai.ea      = ea_q;
		ai.npc     = npc_q;
		ai.a       = a_q;
		ai.x       = x_q;
		ai.y       = y_q;
		ai.sp      = sp_q;
		ai.fl      = fl_q;
		ai.brk_vec = brk_q;
		ai.pulled  = pull_q;
	end

	etu_alu u_alu (
		.ai(ai),
		.ao(ao)
	);

	// result number cnt_q during emit; a write-free instruction still gives one result
	assign nres    = (ao.nw == 2'd0) ? 2'd1 : ao.nw;
	assign is_last = (cnt_q == nres - 2'd1);
	assign w_here  = (cnt_q < ao.nw);
	assign cur_wa  = w_here ? ao.wa[cnt_q] : 16'd0;
	assign cur_wd  = w_here ? ao.wd[cnt_q] : 8'd0;

	// stack reads walk upward from sp + 1, one byte per cycle
	assign ram_raddr = sp_q + {6'd0, cnt_q} + 8'd1;
	// any write that lands in the stack page updates the copy, pushes and stores alike
	assign ram_we    = (state_q == ST_EMIT) && out_free && w_here
	                   && etu_pkg::in_stack_page(cur_wa);
	assign ram_waddr = etu_pkg::stack_index(cur_wa);
	assign ram_wdata = cur_wd;
	// never-written bytes read as zero
	assign pull_byte = rvb_s1 ? ram_rdata : 8'd0;

	etu_ram #(
		.WIDTH(8),
		.DEPTH(etu_pkg::STACK_DEPTH)
	) u_stack (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// latched request payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q    <= s_tuser[5:0];
			to_acc_q  <= s_tuser[6];
			operand_q <= s_tdata[7:0];
			ea_q      <= s_tdata[23:8];
			npc_q     <= s_tdata[39:24];
			npull_q   <= in_npull;
		end
		rvb_s1 <= vb_q[ram_raddr];
		if (state_q == ST_PULL && cnt_q != 2'd0) begin
			pull_q[cnt_q - 2'd1] <= pull_byte;
		end
		if (state_q == ST_EMIT && out_free) begin
			m_data_q <= {etu_pkg::status_of(ao.fl), ao.sp, ao.y, ao.x, ao.a, ao.pc,
			             cur_wd, cur_wa};
			m_user_q <= {ao.illegal, w_here};
			m_last_q <= is_last;
		end
	end

	// sequencer and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= 2'd0;
			m_valid_q <= 1'b0;
			vb_q      <= '0;
			a_q       <= 8'd0;
			x_q       <= 8'd0;
			y_q       <= 8'd0;
			sp_q      <= etu_pkg::SP_RESET;
			fl_q      <= etu_pkg::FLAGS_RESET;
			brk_q     <= 16'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				brk_q <= cfg_data;
			end
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (ram_we) begin
				vb_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						cnt_q   <= 2'd0;
						state_q <= (in_npull != 2'd0) ? ST_PULL : ST_EMIT;
					end
				end
				ST_PULL: begin
					// last pull byte lands in the same cycle we leave
					if (cnt_q == npull_q) begin
						cnt_q   <= 2'd0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						if (is_last) begin
							// commit architectural state with the final result
							a_q     <= ao.a;
							x_q     <= ao.x;
							y_q     <= ao.y;
							sp_q    <= ao.sp;
							fl_q    <= ao.fl;
							cnt_q   <= 2'd0;
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 2'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/etu_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module etu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- design/etu_alu.sv -----
// instruction semantics: next registers, flags, pc and the ordered write list
// depends on etu_pkg
`default_nettype none
module etu_alu (
	input  wire etu_pkg::alu_in_t  ai,
	output etu_pkg::alu_out_t      ao
);
	logic [7:0] src, r, spv, addm, creg, cm;
	logic [5:0] fl;
	logic [1:0] nw;
	logic [2:0][15:0] wa;
	logic [2:0][7:0]  wd;
	logic [15:0] pc, ret;
	logic do_add, do_cmp, take, ill;
	logic [8:0] sum;
	logic [7:0] ar, nz_v;
	logic do_nz;

	always_comb begin
		ao = '0;
		ao.a = ai.a;
		ao.x = ai.x;
		ao.y = ai.y;
		fl = ai.fl;
		spv = ai.sp;
		pc = ai.npc;
		nw = 2'd0;
		wa = '0;
		wd = '0;
		src = ai.to_acc ? ai.a : ai.operand;
		r = 8'd0;
		addm = 8'd0;
		creg = 8'd0;
		cm = 8'd0;
		do_add = 1'b0;
		do_cmp = 1'b0;
		take = 1'b0;
		ill = 1'b0;
		nz_v = 8'd0;
		do_nz = 1'b0;
		ret = ai.npc - 16'd1;
		sum = 9'd0;
		ar = 8'd0;
		unique case (ai.kind)
			etu_pkg::K_LDA: begin ao.a = ai.operand; nz_v = ai.operand; do_nz = 1'b1; end
			etu_pkg::K_LDX: begin ao.x = ai.operand; nz_v = ai.operand; do_nz = 1'b1; end
			etu_pkg::K_LDY: begin ao.y = ai.operand; nz_v = ai.operand; do_nz = 1'b1; end
			etu_pkg::K_STA: begin wa[0] = ai.ea; wd[0] = ai.a; nw = 2'd1; end
			etu_pkg::K_STX: begin wa[0] = ai.ea; wd[0] = ai.x; nw = 2'd1; end
			etu_pkg::K_STY: begin wa[0] = ai.ea; wd[0] = ai.y; nw = 2'd1; end
			etu_pkg::K_TAX: begin ao.x = ai.a; nz_v = ai.a; do_nz = 1'b1; end
			etu_pkg::K_TAY: begin ao.y = ai.a; nz_v = ai.a; do_nz = 1'b1; end
			etu_pkg::K_TXA: begin ao.a = ai.x; nz_v = ai.x; do_nz = 1'b1; end
			etu_pkg::K_TYA: begin ao.a = ai.y; nz_v = ai.y; do_nz = 1'b1; end
			etu_pkg::K_TSX: begin ao.x = ai.sp; nz_v = ai.sp; do_nz = 1'b1; end
			etu_pkg::K_TXS: spv = ai.x;
			etu_pkg::K_PHA: begin
				wa[0] = etu_pkg::BASE16 + {8'd0, ai.sp}; wd[0] = ai.a; nw = 2'd1;
				spv = ai.sp - 8'd1;
			end
			etu_pkg::K_PHP: begin
				wa[0] = etu_pkg::BASE16 + {8'd0, ai.sp};
				wd[0] = etu_pkg::status_of(ai.fl) | etu_pkg::BRK_MARK;
				nw = 2'd1;
				spv = ai.sp - 8'd1;
			end
			etu_pkg::K_PLA: begin
				ao.a = ai.pulled[0]; nz_v = ai.pulled[0]; do_nz = 1'b1;
				spv = ai.sp + 8'd1;
			end
			etu_pkg::K_PLP: begin
				fl = {ai.pulled[0][7:6], ai.pulled[0][3:0]};
				spv = ai.sp + 8'd1;
			end
			etu_pkg::K_ADC: begin addm = ai.operand; do_add = 1'b1; end
			etu_pkg::K_SBC: begin addm = ai.operand ^ etu_pkg::ALL_ONES; do_add = 1'b1; end
			etu_pkg::K_CMP: begin creg = ai.a; cm = ai.operand; do_cmp = 1'b1; end
			etu_pkg::K_CPX: begin creg = ai.x; cm = ai.operand; do_cmp = 1'b1; end
			etu_pkg::K_CPY: begin creg = ai.y; cm = ai.operand; do_cmp = 1'b1; end
			etu_pkg::K_INC, etu_pkg::K_DEC, etu_pkg::K_ASL,
			etu_pkg::K_LSR, etu_pkg::K_ROL, etu_pkg::K_ROR: begin
				case (ai.kind)
					etu_pkg::K_INC: r = src + 8'd1;
					etu_pkg::K_DEC: r = src - 8'd1;
					etu_pkg::K_ASL: begin r = {src[6:0], 1'b0}; fl[etu_pkg::F_C] = src[7]; end
					etu_pkg::K_LSR: begin r = {1'b0, src[7:1]}; fl[etu_pkg::F_C] = src[0]; end
					etu_pkg::K_ROL: begin
						r = {src[6:0], ai.fl[etu_pkg::F_C]}; fl[etu_pkg::F_C] = src[7];
					end
					default: begin
						r = {ai.fl[etu_pkg::F_C], src[7:1]}; fl[etu_pkg::F_C] = src[0];
					end
				endcase
				if (ai.to_acc) begin
					ao.a = r;
				end else begin
					wa[0] = ai.ea; wd[0] = r; nw = 2'd1;
				end
				nz_v = r; do_nz = 1'b1;
			end
			etu_pkg::K_INX: begin ao.x = ai.x + 8'd1; nz_v = ai.x + 8'd1; do_nz = 1'b1; end
			etu_pkg::K_INY: begin ao.y = ai.y + 8'd1; nz_v = ai.y + 8'd1; do_nz = 1'b1; end
			etu_pkg::K_DEX: begin ao.x = ai.x - 8'd1; nz_v = ai.x - 8'd1; do_nz = 1'b1; end
			etu_pkg::K_DEY: begin ao.y = ai.y - 8'd1; nz_v = ai.y - 8'd1; do_nz = 1'b1; end
			etu_pkg::K_AND: begin
				ao.a = ai.a & ai.operand; nz_v = ai.a & ai.operand; do_nz = 1'b1;
			end
			etu_pkg::K_EOR: begin
				ao.a = ai.a ^ ai.operand; nz_v = ai.a ^ ai.operand; do_nz = 1'b1;
			end
			etu_pkg::K_ORA: begin
				ao.a = ai.a | ai.operand; nz_v = ai.a | ai.operand; do_nz = 1'b1;
			end
			etu_pkg::K_BIT: begin
				fl[etu_pkg::F_Z] = (ai.a & ai.operand) == 8'd0;
				fl[etu_pkg::F_N] = ai.operand[7];
				fl[etu_pkg::F_V] = ai.operand[6];
			end
			etu_pkg::K_JMP: pc = ai.ea;
			etu_pkg::K_JSR: begin
				wa[0] = etu_pkg::BASE16 + {8'd0, ai.sp}; wd[0] = ret[15:8];
				wa[1] = etu_pkg::BASE16 + {8'd0, ai.sp - 8'd1}; wd[1] = ret[7:0];
				nw = 2'd2;
				spv = ai.sp - 8'd2;
				pc = ai.ea;
			end
			etu_pkg::K_RTS: begin
				pc = {ai.pulled[1], ai.pulled[0]} + 16'd1;
				spv = ai.sp + 8'd2;
			end
			etu_pkg::K_BCC: take = !ai.fl[etu_pkg::F_C];
			etu_pkg::K_BCS: take = ai.fl[etu_pkg::F_C];
			etu_pkg::K_BEQ: take = ai.fl[etu_pkg::F_Z];
			etu_pkg::K_BMI: take = ai.fl[etu_pkg::F_N];
			etu_pkg::K_BNE: take = !ai.fl[etu_pkg::F_Z];
			etu_pkg::K_BPL: take = !ai.fl[etu_pkg::F_N];
			etu_pkg::K_BVC: take = !ai.fl[etu_pkg::F_V];
			etu_pkg::K_BVS: take = ai.fl[etu_pkg::F_V];
			etu_pkg::K_CLC: fl[etu_pkg::F_C] = 1'b0;
			etu_pkg::K_CLD: fl[etu_pkg::F_D] = 1'b0;
			etu_pkg::K_CLI: fl[etu_pkg::F_I] = 1'b0;
			etu_pkg::K_CLV: fl[etu_pkg::F_V] = 1'b0;
			etu_pkg::K_SEC: fl[etu_pkg::F_C] = 1'b1;
			etu_pkg::K_SED: fl[etu_pkg::F_D] = 1'b1;
			etu_pkg::K_SEI: fl[etu_pkg::F_I] = 1'b1;
			etu_pkg::K_BRK: begin
				wa[0] = etu_pkg::BASE16 + {8'd0, ai.sp}; wd[0] = ret[15:8];
				wa[1] = etu_pkg::BASE16 + {8'd0, ai.sp - 8'd1}; wd[1] = ret[7:0];
				wa[2] = etu_pkg::BASE16 + {8'd0, ai.sp - 8'd2};
				wd[2] = etu_pkg::status_of(ai.fl) | etu_pkg::BRK_MARK;
				nw = 2'd3;
				spv = ai.sp - 8'd3;
				pc = ai.brk_vec;
			end
			etu_pkg::K_NOP: ;
			etu_pkg::K_RTI: begin
				fl = {ai.pulled[0][7:6], ai.pulled[0][3:0]};
				pc = {ai.pulled[2], ai.pulled[1]};
				spv = ai.sp + 8'd3;
			end
			etu_pkg::K_LAX: begin
				ao.a = ai.operand; ao.x = ai.operand; nz_v = ai.operand; do_nz = 1'b1;
			end
			etu_pkg::K_SAX: begin wa[0] = ai.ea; wd[0] = ai.a & ai.x; nw = 2'd1; end
			etu_pkg::K_DCP: begin
				r = ai.operand - 8'd1;
				wa[0] = ai.ea; wd[0] = r; nw = 2'd1;
				creg = ai.a; cm = r; do_cmp = 1'b1;
			end
			etu_pkg::K_ISB: begin
				r = ai.operand + 8'd1;
				wa[0] = ai.ea; wd[0] = r; nw = 2'd1;
				addm = r ^ etu_pkg::ALL_ONES; do_add = 1'b1;
			end
			default: ill = 1'b1;
		endcase
		if (do_add) begin
			sum = {1'b0, ai.a} + {1'b0, addm} + {8'd0, ai.fl[etu_pkg::F_C]};
			ar = sum[7:0];
			fl[etu_pkg::F_V] = ~(ai.a[7] ^ addm[7]) & (ai.a[7] ^ ar[7]);
			fl[etu_pkg::F_C] = sum[8];
			ao.a = ar;
			nz_v = ar;
			do_nz = 1'b1;
		end
		if (do_cmp) begin
			nz_v = creg - cm;
			do_nz = 1'b1;
			fl[etu_pkg::F_C] = creg >= cm;
		end
		if (do_nz) begin
			fl[etu_pkg::F_Z] = nz_v == 8'd0;
			fl[etu_pkg::F_N] = nz_v[7];
		end
		if (take) begin
			pc = ai.ea;
		end
		ao.fl = fl;
		ao.sp = spv;
		ao.pc = pc;
		ao.nw = nw;
		ao.wa = wa;
		ao.wd = wd;
		ao.illegal = ill;
	end
endmodule
`default_nettype wire

// ----- design/etu_checker.sv -----
// port-level checks on the execute unit results, bound to the top level
// depends on eight_bit_cpu_execute_unit_core
`default_nettype none
module etu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [79:0] m_tdata,
	input wire logic [1:0]  m_tuser,
	input wire logic        m_tlast
);
	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// results without a write carry zero address and data
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[23:0] == 24'd0)
		else $error("write fields set without write");

	// illegal code gives a single result with no write
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
		else $error("illegal result malformed");

	// status bit 5 reads as one
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[77])
		else $error("status bit 5 clear");
endmodule

bind eight_bit_cpu_execute_unit_core etu_checker u_etu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser),
	.m_tlast(m_tlast)
);
`default_nettype wire
